// ===== design/sbg_pkg.sv =====
// Package for the spike burst grouper: widths, codes and request types.
`timescale 1ns / 1ps

package sbg_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned COUNT_BITS  = 8;
  localparam int unsigned INDEX_BITS  = 16;
  localparam int unsigned TOTAL_BITS  = 24;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(8960);

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0
  } reg_idx_e;

  typedef enum logic [1:0] {
    PK_NONE  = 2'd0,
    PK_SPIKE = 2'd1,
    PK_SUB   = 2'd2
  } peak_kind_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] voltage_sample;
    logic                          restart;
  } sbg_in_t;

  typedef struct packed {
    peak_kind_e              peak_kind;
    logic [INDEX_BITS-1:0]   group_index;
    logic [COUNT_BITS-1:0]   spikes_in_group;
    logic                    group_closed;
    logic [COUNT_BITS-1:0]   closed_group_count;
    logic [INDEX_BITS-1:0]   gap_index;
    logic [COUNT_BITS-1:0]   subpeaks_in_gap;
    logic [TOTAL_BITS-1:0]   spike_total;
    logic [TOTAL_BITS-1:0]   subpeak_total;
  } sbg_out_t;

endpackage

// ===== design/spike_burst_grouper.sv =====
// Top level of the spike burst grouper: handshake, register port and result stage.
// Requests pass the input register, then the core, then the result register.
// Throughput: one request per cycle while results are taken; input register
// and result register each hold one request, so a waiting result blocks the
// input only once the input register is also full.
// Reset (rst_ni low, asynchronous): run state and valid flags cleared,
// spike_threshold returns to 8960 (70 mV).
`timescale 1ns / 1ps

module spike_burst_grouper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sbg_pkg::sbg_in_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sbg_pkg::sbg_out_t             out_req_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbg_pkg::APB_AW-1:0]    paddr,
  input  logic [sbg_pkg::APB_DW-1:0]    pwdata,
  output logic [sbg_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import sbg_pkg::*;

  logic signed [SAMPLE_BITS-1:0] thr_q;
  sbg_in_t                       in_q;
  logic                          in_valid_q;
  sbg_out_t                      out_q, result;
  logic                          out_valid_q;
  logic                          out_adv, step;
  reg_idx_e                      reg_idx;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = APB_DW'(thr_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && reg_idx == REG_THRESHOLD) begin
      thr_q <= pwdata[SAMPLE_BITS-1:0];
    end
  end

  assign out_adv    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_adv;
  assign in_ready_o = !in_valid_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_req_i;
    end
    if (step) begin
      out_q <= result;
    end
  end

  sbg_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .threshold_i (thr_q),
    .result_o    (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== design/sbg_core.sv =====
// Peak judgement and group/gap counter state of the spike burst grouper.
`timescale 1ns / 1ps

module sbg_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  sbg_pkg::sbg_in_t                     item_i,
  input  logic signed [sbg_pkg::SAMPLE_BITS-1:0] threshold_i,
  output sbg_pkg::sbg_out_t                    result_o
);
  import sbg_pkg::*;

  logic signed [SAMPLE_BITS-1:0] older_q, older_d, middle_q, middle_d;
  logic signed [SAMPLE_BITS-1:0] older, middle;
  logic [1:0]                    held_q, held_d, held;
  peak_kind_e                    last_q, last_d, last_kind, kind;
  logic [COUNT_BITS-1:0]         grp_cnt_q, grp_cnt_d, grp_cnt;
  logic [INDEX_BITS-1:0]         grp_num_q, grp_num_d, grp_num;
  logic [COUNT_BITS-1:0]         gap_cnt_q, gap_cnt_d, gap_cnt;
  logic [INDEX_BITS-1:0]         gap_num_q, gap_num_d, gap_num;
  logic [TOTAL_BITS-1:0]         tot_spk_q, tot_spk_d, tot_spk;
  logic [TOTAL_BITS-1:0]         tot_sub_q, tot_sub_d, tot_sub;
  logic                          closed;
  logic [COUNT_BITS-1:0]         closed_cnt;

  // restart clears the run before the sample is judged
  always_comb begin
    if (item_i.restart) begin
      older     = '0;
      middle    = '0;
      held      = 2'd0;
      last_kind = PK_NONE;
      grp_cnt   = '0;
      grp_num   = '0;
      gap_cnt   = '0;
      gap_num   = '0;
      tot_spk   = '0;
      tot_sub   = '0;
    end else begin
      older     = older_q;
      middle    = middle_q;
      held      = held_q;
      last_kind = last_q;
      grp_cnt   = grp_cnt_q;
      grp_num   = grp_num_q;
      gap_cnt   = gap_cnt_q;
      gap_num   = gap_num_q;
      tot_spk   = tot_spk_q;
      tot_sub   = tot_sub_q;
    end
  end

  always_comb begin
    kind = PK_NONE;
    if (held == 2'd2 && middle >= older && middle >= item_i.voltage_sample) begin
      if (middle > threshold_i) begin
        kind = PK_SPIKE;
      end else if (middle < threshold_i) begin
        kind = PK_SUB;
      end
    end
  end

  always_comb begin
    grp_cnt_d  = grp_cnt;
    grp_num_d  = grp_num;
    gap_cnt_d  = gap_cnt;
    gap_num_d  = gap_num;
    tot_spk_d  = tot_spk;
    tot_sub_d  = tot_sub;
    last_d     = last_kind;
    closed     = 1'b0;
    closed_cnt = '0;
    case (kind)
      PK_SPIKE: begin
        tot_spk_d = (&tot_spk) ? tot_spk : tot_spk + TOTAL_BITS'(1);
        if (last_kind == PK_SUB) begin
          gap_num_d = (&gap_num) ? gap_num : gap_num + INDEX_BITS'(1);
          gap_cnt_d = '0;
        end
        grp_cnt_d = (&grp_cnt) ? grp_cnt : grp_cnt + COUNT_BITS'(1);
        last_d    = PK_SPIKE;
      end
      PK_SUB: begin
        tot_sub_d = (&tot_sub) ? tot_sub : tot_sub + TOTAL_BITS'(1);
        if (last_kind == PK_SPIKE) begin
          closed     = 1'b1;
          closed_cnt = grp_cnt;
          grp_num_d  = (&grp_num) ? grp_num : grp_num + INDEX_BITS'(1);
          grp_cnt_d  = '0;
        end
        gap_cnt_d = (&gap_cnt_d) ? gap_cnt_d : gap_cnt_d + COUNT_BITS'(1);
        last_d    = PK_SUB;
      end
      default: ;
    endcase
    older_d  = middle;
    middle_d = item_i.voltage_sample;
    held_d   = (held == 2'd2) ? held : held + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q   <= '0;
      middle_q  <= '0;
      held_q    <= 2'd0;
      last_q    <= PK_NONE;
      grp_cnt_q <= '0;
      grp_num_q <= '0;
      gap_cnt_q <= '0;
      gap_num_q <= '0;
      tot_spk_q <= '0;
      tot_sub_q <= '0;
    end else if (step_i) begin
      older_q   <= older_d;
      middle_q  <= middle_d;
      held_q    <= held_d;
      last_q    <= last_d;
      grp_cnt_q <= grp_cnt_d;
      grp_num_q <= grp_num_d;
      gap_cnt_q <= gap_cnt_d;
      gap_num_q <= gap_num_d;
      tot_spk_q <= tot_spk_d;
      tot_sub_q <= tot_sub_d;
    end
  end

  always_comb begin
    result_o.peak_kind          = kind;
    result_o.group_index        = grp_num_d;
    result_o.spikes_in_group    = grp_cnt_d;
    result_o.group_closed       = closed;
    result_o.closed_group_count = closed_cnt;
    result_o.gap_index          = gap_num_d;
    result_o.subpeaks_in_gap    = gap_cnt_d;
    result_o.spike_total        = tot_spk_d;
    result_o.subpeak_total      = tot_sub_d;
  end

endmodule

// ===== tb/spike_burst_grouper_tb.sv =====
// Testbench for spike_burst_grouper: directed and random samples checked by predictor or fixed rows.
`timescale 1ns / 1ps

module spike_burst_grouper_tb;
  import sbg_pkg::*;

  localparam logic [APB_AW-1:0] THR_ADDR   = APB_AW'(4 * REG_THRESHOLD);
  localparam int unsigned       SPARE_REG  = 1;
  localparam logic [APB_AW-1:0] SPARE_ADDR = APB_AW'(4 * SPARE_REG);

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] v;
    logic                          rs;
    bit                            typed;
    sbg_out_t                      fixed;
  } dir_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  sbg_in_t           in_req_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  sbg_out_t          out_req_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // predictor state
  logic signed [SAMPLE_BITS-1:0] thr_q;
  logic signed [SAMPLE_BITS-1:0] hist_old, hist_mid;
  int                            hist_cnt;
  peak_kind_e                    prior_kind;
  logic [COUNT_BITS-1:0]         grp_spikes, gap_subs;
  logic [INDEX_BITS-1:0]         grp_no, gap_no;
  logic [TOTAL_BITS-1:0]         spike_sum, sub_sum;

  sbg_out_t expected_counts[$];
  dir_row_t dir_rows[$];
  int       errors     = 0;
  int       stall_left = 0;
  bit       calm       = 1'b0;

  spike_burst_grouper i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic clear_run();
    hist_old   = '0;
    hist_mid   = '0;
    hist_cnt   = 0;
    prior_kind = PK_NONE;
    grp_spikes = '0;
    grp_no     = '0;
    gap_subs   = '0;
    gap_no     = '0;
    spike_sum  = '0;
    sub_sum    = '0;
  endtask

  task automatic judge_sample(input sbg_in_t req, output sbg_out_t res);
    logic signed [SAMPLE_BITS-1:0] new_v;
    peak_kind_e                    kind;
    new_v = req.voltage_sample;
    kind  = PK_NONE;
    res   = '0;
    if (req.restart) clear_run();
    if (hist_cnt >= 2 && hist_mid >= hist_old && hist_mid >= new_v) begin
      if (hist_mid > thr_q) kind = PK_SPIKE;
      else if (hist_mid < thr_q) kind = PK_SUB;
    end
    if (kind == PK_SPIKE) begin
      if (~&spike_sum) spike_sum++;
      if (prior_kind == PK_SUB) begin
        if (~&gap_no) gap_no++;
        gap_subs = '0;
      end
      if (~&grp_spikes) grp_spikes++;
      prior_kind = PK_SPIKE;
    end else if (kind == PK_SUB) begin
      if (~&sub_sum) sub_sum++;
      if (prior_kind == PK_SPIKE) begin
        res.group_closed       = 1'b1;
        res.closed_group_count = grp_spikes;
        if (~&grp_no) grp_no++;
        grp_spikes = '0;
      end
      if (~&gap_subs) gap_subs++;
      prior_kind = PK_SUB;
    end
    hist_old = hist_mid;
    hist_mid = new_v;
    if (hist_cnt < 2) hist_cnt++;
    res.peak_kind       = kind;
    res.group_index     = grp_no;
    res.spikes_in_group = grp_spikes;
    res.gap_index       = gap_no;
    res.subpeaks_in_gap = gap_subs;
    res.spike_total     = spike_sum;
    res.subpeak_total   = sub_sum;
  endtask

  function automatic sbg_out_t opening_result(peak_kind_e k, int n);
    sbg_out_t r;
    r                 = '0;
    r.peak_kind       = k;
    r.spikes_in_group = COUNT_BITS'(n);
    r.spike_total     = TOTAL_BITS'(n);
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] clamp_v(int x);
    if (x > 32767) return 16'sd32767;
    if (x < -32768) return -16'sd32768;
    return SAMPLE_BITS'(x);
  endfunction

  task automatic field_chk(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic compare_counts(input sbg_out_t want, input sbg_out_t got);
    field_chk("peak_kind", want.peak_kind, got.peak_kind);
    field_chk("group_index", want.group_index, got.group_index);
    field_chk("spikes_in_group", want.spikes_in_group, got.spikes_in_group);
    field_chk("group_closed", want.group_closed, got.group_closed);
    field_chk("closed_group_count", want.closed_group_count, got.closed_group_count);
    field_chk("gap_index", want.gap_index, got.gap_index);
    field_chk("subpeaks_in_gap", want.subpeaks_in_gap, got.subpeaks_in_gap);
    field_chk("spike_total", want.spike_total, got.spike_total);
    field_chk("subpeak_total", want.subpeak_total, got.subpeak_total);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: result with no request pending: %p", $time, out_req_o);
        errors++;
      end else begin
        compare_counts(expected_counts.pop_front(), out_req_o);
      end
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk_i) begin
    if (calm) stall_left = 0;
    else if (stall_left == 0 && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
    out_ready_i <= (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v, input logic rs,
                             input bit typed, input sbg_out_t fixed);
    sbg_in_t  req;
    sbg_out_t want;
    req.voltage_sample = v;
    req.restart        = rs;
    if (!calm && $urandom_range(0, 11) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    judge_sample(req, want);
    expected_counts.push_back(typed ? fixed : want);
  endtask

  task automatic send_plateau(input logic signed [SAMPLE_BITS-1:0] v, input int len);
    repeat (len) send_sample(v, 1'b0, 1'b0, '0);
  endtask

  // mostly trough-peak-trough shapes around the threshold, some noise and restarts
  task automatic send_waveform(input int n);
    int sent, pick, peak, trough, reps;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_sample(SAMPLE_BITS'($urandom), 1'b1, 1'b0, '0);
        sent++;
      end else if (pick < 15) begin
        send_sample(SAMPLE_BITS'($urandom), 1'b0, 1'b0, '0);
        sent++;
      end else begin
        case ($urandom_range(0, 7))
          0, 1, 2, 3: peak = int'(thr_q) + int'($urandom_range(1, 2000));
          7:          peak = int'(thr_q);
          default:    peak = int'(thr_q) - int'($urandom_range(1, 2000));
        endcase
        trough = peak - int'($urandom_range(0, 4000));
        reps   = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        send_sample(clamp_v(trough), 1'b0, 1'b0, '0);
        repeat (reps) send_sample(clamp_v(peak), 1'b0, 1'b0, '0);
        send_sample(clamp_v(trough), 1'b0, 1'b0, '0);
        sent += reps + 2;
      end
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                          input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_threshold();
    logic [APB_DW-1:0] rd;
    apb_xfer(1'b0, THR_ADDR, '0, rd);
    if (rd[SAMPLE_BITS-1:0] !== thr_q) begin
      $display("%0t: spike_threshold expected %0d, got %0d", $time, thr_q,
               $signed(rd[SAMPLE_BITS-1:0]));
      errors++;
    end
  endtask

  task automatic set_threshold(input logic signed [SAMPLE_BITS-1:0] v);
    logic [APB_DW-1:0] rd;
    apb_xfer(1'b1, THR_ADDR, APB_DW'(v), rd);
    thr_q = v;
    check_threshold();
  endtask

  task automatic add_row(input int v, input logic rs, input bit typed, input sbg_out_t fixed);
    dir_row_t row;
    row.v     = SAMPLE_BITS'(v);
    row.rs    = rs;
    row.typed = typed;
    row.fixed = fixed;
    dir_rows.push_back(row);
  endtask

  initial begin
    logic [APB_DW-1:0] rd;
    clear_run();
    thr_q = THRESHOLD_RESET;

    // first rows read straight off the reset state
    add_row(0,      1'b0, 1'b1, opening_result(PK_NONE, 0));
    add_row(-32768, 1'b0, 1'b1, opening_result(PK_NONE, 0));
    add_row(32767,  1'b0, 1'b1, opening_result(PK_NONE, 0));
    add_row(-32768, 1'b0, 1'b1, opening_result(PK_SPIKE, 1));
    add_row(8960,   1'b0, 1'b0, '0);
    add_row(8960,   1'b0, 1'b0, '0);  // peak at threshold, twice
    add_row(0,      1'b0, 1'b0, '0);
    add_row(100,    1'b0, 1'b0, '0);
    add_row(0,      1'b0, 1'b0, '0);  // subthreshold peak closes the group
    add_row(200,    1'b0, 1'b0, '0);
    add_row(0,      1'b0, 1'b0, '0);
    add_row(9000,   1'b0, 1'b0, '0);
    add_row(0,      1'b0, 1'b0, '0);  // spike opens a new gap
    add_row(9000,   1'b0, 1'b0, '0);
    add_row(9000,   1'b0, 1'b0, '0);
    add_row(0,      1'b0, 1'b0, '0);
    add_row(32767,  1'b1, 1'b0, '0);  // restart mid-run
    add_row(32767,  1'b0, 1'b0, '0);
    add_row(32767,  1'b0, 1'b0, '0);
    add_row(-1,     1'b1, 1'b0, '0);
    add_row(-2,     1'b1, 1'b0, '0);
    add_row(-1,     1'b0, 1'b0, '0);
    add_row(-32768, 1'b0, 1'b0, '0);
    add_row(-32768, 1'b0, 1'b0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_threshold();
    foreach (dir_rows[i]) send_sample(dir_rows[i].v, dir_rows[i].rs, dir_rows[i].typed,
                                      dir_rows[i].fixed);
    settle();

    // lowest threshold: a flat run is a spike every request, group count saturates
    set_threshold(-16'sd32768);
    send_plateau(clamp_v(int'($urandom_range(1, 65535)) - 32768), 270);
    send_waveform(60);
    settle();

    // highest threshold: a flat run saturates the gap count
    set_threshold(16'sd32767);
    send_plateau(clamp_v(int'($urandom_range(0, 65534)) - 32768), 270);
    send_waveform(60);
    settle();

    // unused register must leave the threshold alone
    apb_xfer(1'b1, SPARE_ADDR, $urandom, rd);
    check_threshold();
    set_threshold(16'sd0);
    send_waveform(200);
    settle();

    set_threshold(SAMPLE_BITS'($urandom));
    send_waveform(120);
    calm = 1'b1;
    send_waveform(100);
    settle();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
